>>> rtl/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define CAU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CAU_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int QUOT_W    = DATA_W + 1;
   localparam int NUM_W     = PROD_W + FRAC_BITS;
   localparam int CMP_W     = PROD_W + QUOT_W;
   localparam int DIV_STEPS = QUOT_W;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_DBZ = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   typedef struct packed {
      logic              is_div;
      logic              dbz;
      logic              neg_re;
      logic              neg_im;
      logic              ovf_re;
      logic              ovf_im;
      logic [PROD_W-1:0] mag_re;
      logic [PROD_W-1:0] mag_im;
      logic [PROD_W-1:0] den;
      logic [PROD_W-1:0] rem_re;
      logic [PROD_W-1:0] rem_im;
      logic [QUOT_W-1:0] num_re;
      logic [QUOT_W-1:0] num_im;
      logic [QUOT_W-1:0] q_re;
      logic [QUOT_W-1:0] q_im;
   } work_type;
endpackage
`default_nettype wire

>>> rtl/cau_front.sv
// Front end: products, sums, sign/magnitude split and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module cau_front
   import cau_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [1:0]               in_action,
   input  wire logic signed [DATA_W-1:0] in_a_re,
   input  wire logic signed [DATA_W-1:0] in_a_im,
   input  wire logic signed [DATA_W-1:0] in_b_re,
   input  wire logic signed [DATA_W-1:0] in_b_im,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output work_type                      out_data
);
   // stage 1: products and plain sums
   logic                     v1_ff;
   action_type               act1_ff;
   logic                     bz1_ff;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff, ir_ff, sr_ff, si_ff;
   logic        [DATA_W:0]   add_re_ff, add_im_ff;
   logic        [DATA_W:0]   add_re_in, add_im_in;
   logic                     rdy1;

   // stage 2: sign and magnitude
   logic                     v2_ff;
   logic                     div2_ff, bz2_ff, neg_re_ff, neg_im_ff;
   logic        [PROD_W-1:0] mag_re_ff, mag_im_ff, den_ff;
   logic        [PROD_W:0]   s_re, s_im, abs_re, abs_im;
   logic        [PROD_W-1:0] mag_re_in, mag_im_in;
   logic                     rdy2;

   // stage 3: divider setup
   logic                     v3_ff;
   work_type                 w3_ff;
   work_type                 w3_in;
   logic        [NUM_W-1:0]  n_re, n_im;
   logic        [CMP_W-1:0]  den_lim;

   assign rdy2     = !v3_ff || out_ready;
   assign rdy1     = !v2_ff || rdy2;
   assign in_ready = !v1_ff || rdy1;

   always_comb begin
      if (action_type'(in_action) == ACT_SUB) begin
         add_re_in = {in_a_re[DATA_W-1], in_a_re} - {in_b_re[DATA_W-1], in_b_re};
         add_im_in = {in_a_im[DATA_W-1], in_a_im} - {in_b_im[DATA_W-1], in_b_im};
      end else begin
         add_re_in = {in_a_re[DATA_W-1], in_a_re} + {in_b_re[DATA_W-1], in_b_re};
         add_im_in = {in_a_im[DATA_W-1], in_a_im} + {in_b_im[DATA_W-1], in_b_im};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (in_ready) begin
         v1_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         act1_ff   <= action_type'(in_action);
         bz1_ff    <= (in_b_re == '0) && (in_b_im == '0);
         rr_ff     <= in_a_re * in_b_re;
         ii_ff     <= in_a_im * in_b_im;
         ri_ff     <= in_a_re * in_b_im;
         ir_ff     <= in_a_im * in_b_re;
         sr_ff     <= in_b_re * in_b_re;
         si_ff     <= in_b_im * in_b_im;
         add_re_ff <= add_re_in;
         add_im_ff <= add_im_in;
      end
   end

   always_comb begin
      case (act1_ff)
         ACT_MUL: begin
            s_re = {rr_ff[PROD_W-1], rr_ff} - {ii_ff[PROD_W-1], ii_ff};
            s_im = {ri_ff[PROD_W-1], ri_ff} + {ir_ff[PROD_W-1], ir_ff};
         end
         ACT_DIV: begin
            s_re = {rr_ff[PROD_W-1], rr_ff} + {ii_ff[PROD_W-1], ii_ff};
            s_im = {ir_ff[PROD_W-1], ir_ff} - {ri_ff[PROD_W-1], ri_ff};
         end
         default: begin
            s_re = {{(PROD_W-DATA_W){add_re_ff[DATA_W]}}, add_re_ff};
            s_im = {{(PROD_W-DATA_W){add_im_ff[DATA_W]}}, add_im_ff};
         end
      endcase
      abs_re = s_re[PROD_W] ? -s_re : s_re;
      abs_im = s_im[PROD_W] ? -s_im : s_im;
      mag_re_in = abs_re[PROD_W-1:0];
      mag_im_in = abs_im[PROD_W-1:0];
      if (act1_ff == ACT_MUL) begin
         mag_re_in = mag_re_in >> FRAC_BITS;
         mag_im_in = mag_im_in >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy1) begin
         v2_ff <= v1_ff;
      end
      if (rdy1 && v1_ff) begin
         div2_ff   <= (act1_ff == ACT_DIV);
         bz2_ff    <= bz1_ff;
         neg_re_ff <= s_re[PROD_W];
         neg_im_ff <= s_im[PROD_W];
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
         den_ff    <= sr_ff + si_ff;
      end
   end

   always_comb begin
      n_re    = NUM_W'(mag_re_ff) << FRAC_BITS;
      n_im    = NUM_W'(mag_im_ff) << FRAC_BITS;
      den_lim = CMP_W'(den_ff) << QUOT_W;
      w3_in.is_div = div2_ff;
      w3_in.dbz    = bz2_ff;
      w3_in.neg_re = neg_re_ff;
      w3_in.neg_im = neg_im_ff;
      // quotient would not fit the divider width: saturate outright
      w3_in.ovf_re = CMP_W'(n_re) >= den_lim;
      w3_in.ovf_im = CMP_W'(n_im) >= den_lim;
      w3_in.mag_re = mag_re_ff;
      w3_in.mag_im = mag_im_ff;
      w3_in.den    = den_ff;
      w3_in.rem_re = PROD_W'(n_re >> QUOT_W);
      w3_in.rem_im = PROD_W'(n_im >> QUOT_W);
      w3_in.num_re = n_re[QUOT_W-1:0];
      w3_in.num_im = n_im[QUOT_W-1:0];
      w3_in.q_re   = '0;
      w3_in.q_im   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy2) begin
         v3_ff <= v2_ff;
      end
      if (rdy2 && v2_ff) begin
         w3_ff <= w3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = w3_ff;
endmodule
`default_nettype wire

>>> rtl/cau_div_step.sv
// One restoring division step for both result parts.
`timescale 1ns / 1ps
`default_nettype none
module cau_div_step
   import cau_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire work_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output work_type      out_data
);
   logic              valid_ff;
   work_type          data_ff;
   work_type          data_in;
   logic [PROD_W:0]   r_re, r_im, d_re, d_im;
   logic              ge_re, ge_im;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      r_re  = {in_data.rem_re, in_data.num_re[QUOT_W-1]};
      r_im  = {in_data.rem_im, in_data.num_im[QUOT_W-1]};
      d_re  = r_re - {1'b0, in_data.den};
      d_im  = r_im - {1'b0, in_data.den};
      ge_re = r_re >= {1'b0, in_data.den};
      ge_im = r_im >= {1'b0, in_data.den};
      data_in.rem_re = ge_re ? d_re[PROD_W-1:0] : r_re[PROD_W-1:0];
      data_in.rem_im = ge_im ? d_im[PROD_W-1:0] : r_im[PROD_W-1:0];
      data_in.q_re   = {in_data.q_re[QUOT_W-2:0], ge_re};
      data_in.q_im   = {in_data.q_im[QUOT_W-2:0], ge_im};
      data_in.num_re = in_data.num_re << 1;
      data_in.num_im = in_data.num_im << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

>>> rtl/cau_pack.sv
// Result stage: saturation, status and the output register.
`timescale 1ns / 1ps
`default_nettype none
module cau_pack
   import cau_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire work_type           in_data,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output logic signed [DATA_W-1:0] out_re,
   output logic signed [DATA_W-1:0] out_im,
   output logic [1:0]              out_status
);
   localparam logic [PROD_W-1:0] POS_MAX = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
   localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'({1'b1, {(DATA_W-1){1'b0}}});
   localparam logic [PROD_W-1:0] Q_CLAMP = PROD_W'(1) << DATA_W;

   logic              valid_ff;
   logic [DATA_W-1:0] re_ff, im_ff;
   status_type        status_ff;
   logic [PROD_W-1:0] m_re, m_im;
   logic [DATA_W-1:0] re_in, im_in;
   logic              sat_re, sat_im;
   status_type        status_in;

   function automatic logic [DATA_W:0] sat_pack(input logic neg, input logic [PROD_W-1:0] mag);
      logic [DATA_W-1:0] neg_val;
      neg_val = -mag[DATA_W-1:0];
      if (!neg) begin
         sat_pack = (mag > POS_MAX) ? {1'b1, POS_MAX[DATA_W-1:0]} : {1'b0, mag[DATA_W-1:0]};
      end else begin
         sat_pack = (mag > NEG_MAX) ? {1'b1, NEG_MAX[DATA_W-1:0]} : {1'b0, neg_val};
      end
   endfunction

   assign in_ready = !valid_ff || !out_stall;

   always_comb begin
      if (in_data.is_div) begin
         m_re = in_data.ovf_re ? Q_CLAMP : PROD_W'(in_data.q_re);
         m_im = in_data.ovf_im ? Q_CLAMP : PROD_W'(in_data.q_im);
      end else begin
         m_re = in_data.mag_re;
         m_im = in_data.mag_im;
      end
      {sat_re, re_in} = sat_pack(in_data.neg_re, m_re);
      {sat_im, im_in} = sat_pack(in_data.neg_im, m_im);
      status_in = (sat_re || sat_im) ? ST_SAT : ST_OK;
      if (in_data.is_div && in_data.dbz) begin
         re_in     = '0;
         im_in     = '0;
         status_in = ST_DBZ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         re_ff     <= re_in;
         im_ff     <= im_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_re     = re_ff;
   assign out_im     = im_ff;
   assign out_status = status_ff;
endmodule
`default_nettype wire

>>> rtl/complex_arithmetic_unit.sv
// Top level of the pipelined complex arithmetic unit.
//
//   channel  | ports                                          | direction
//   ---------+------------------------------------------------+----------
//   req      | req_valid, req_stall, req_action, req_a_*,     | in
//            | req_b_*                                        |
//   rsp      | rsp_valid, rsp_stall, rsp_res_re, rsp_res_im,  | out
//            | rsp_status                                     |
//
// One item enters per cycle while req_stall is low; every operation passes through
// three front stages, 33 divider steps (one quotient bit each) and one result
// register. The divider chain sets the depth.
// Reset clears only the valid bits of all stages.
// Each stage moves whenever its successor has room, so a stall at rsp only
// freezes stages that hold an item; bubbles behind it still fill.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_action,
   input  wire logic signed [DATA_W-1:0] req_a_re,
   input  wire logic signed [DATA_W-1:0] req_a_im,
   input  wire logic signed [DATA_W-1:0] req_b_re,
   input  wire logic signed [DATA_W-1:0] req_b_im,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_res_re,
   output logic signed [DATA_W-1:0]      rsp_res_im,
   output logic [1:0]                    rsp_status
);
   // chain links: index 0 is the front output, DIV_STEPS the last divider step
   work_type chain_data  [DIV_STEPS+1];
   logic     chain_valid [DIV_STEPS+1];
   logic     chain_ready [DIV_STEPS+1];
   logic     front_ready;

   // stall the requester whenever the first stage cannot take an item
   assign req_stall = !front_ready;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_action (req_action),
      .in_a_re   (req_a_re),
      .in_a_im   (req_a_im),
      .in_b_re   (req_b_re),
      .in_b_im   (req_b_im),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // one restoring step per stage; non-divide items ride through with their magnitudes untouched
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // saturate, pick the status and hold the item until taken
   cau_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[DIV_STEPS]),
      .in_ready   (chain_ready[DIV_STEPS]),
      .in_data    (chain_data[DIV_STEPS]),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_re     (rsp_res_re),
      .out_im     (rsp_res_im),
      .out_status (rsp_status)
   );
endmodule
`default_nettype wire

>>> rtl/cau_checker.sv
// Port-level checker for the complex arithmetic unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module cau_checker
   import cau_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_res_re,
   input wire logic signed [DATA_W-1:0] rsp_res_im,
   input wire logic [1:0]               rsp_status
);
   logic [DATA_W-1:0]   re_bits, im_bits;
   logic [2*DATA_W+1:0] rsp_bits;
   logic                re_ext, im_ext;
   logic                hold_now, dbz_seen, sat_seen, parts_zero, code_ok;

   assign re_bits  = rsp_res_re;
   assign im_bits  = rsp_res_im;
   assign rsp_bits = {rsp_res_re, rsp_res_im, rsp_status};
   assign re_ext   = (re_bits == {1'b0, {(DATA_W-1){1'b1}}}) ||
                     (re_bits == {1'b1, {(DATA_W-1){1'b0}}});
   assign im_ext   = (im_bits == {1'b0, {(DATA_W-1){1'b1}}}) ||
                     (im_bits == {1'b1, {(DATA_W-1){1'b0}}});

   assign hold_now   = rsp_valid && rsp_stall;
   assign dbz_seen   = rsp_valid && (rsp_status == ST_DBZ);
   assign sat_seen   = rsp_valid && (rsp_status == ST_SAT);
   assign parts_zero = (re_bits == '0) && (im_bits == '0);
   assign code_ok    = (rsp_status == ST_OK) || (rsp_status == ST_DBZ) ||
                       (rsp_status == ST_SAT);

   `CAU_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid right after reset")
   `CAU_ASSERT_NEXT(a_rsp_hold, hold_now, rsp_valid && $stable(rsp_bits), "stalled result changed")
   `CAU_ASSERT_IMPL(a_dbz_zero, dbz_seen, parts_zero, "divide by zero with nonzero parts")
   `CAU_ASSERT_IMPL(a_sat_extreme, sat_seen, re_ext || im_ext, "saturated without an extreme part")
   `CAU_ASSERT_IMPL(a_status_code, rsp_valid, code_ok, "undefined status code")
endmodule

bind complex_arithmetic_unit cau_checker u_checker (.*);
`default_nettype wire

>>> sim/tb_complex_arithmetic_unit.sv
// Self-checking testbench of the complex arithmetic unit.
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
   import cau_pkg::*;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      status_type         status;
   } cplx_result_type;

   // Clamp a sign-magnitude part into 32 bits; flag saturation.
   function automatic logic signed [31:0] clamp_part(input logic neg,
                                                      input logic [127:0] mag,
                                                      inout logic sat);
      if (!neg) begin
         if (mag > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > 128'h8000_0000) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return -mag[31:0];
   endfunction

   // Work out the one result of an item, exact at wide widths.
   function automatic cplx_result_type complex_result(input action_type act,
                                                      input logic signed [31:0] ar,
                                                      input logic signed [31:0] ai,
                                                      input logic signed [31:0] br,
                                                      input logic signed [31:0] bi);
      cplx_result_type r;
      logic signed [67:0] xr, xi;
      logic [127:0] mr, mi, den;
      logic sat;
      sat = 1'b0;
      case (act)
         ACT_ADD: begin
            xr = 68'(ar) + 68'(br);
            xi = 68'(ai) + 68'(bi);
         end
         ACT_SUB: begin
            xr = 68'(ar) - 68'(br);
            xi = 68'(ai) - 68'(bi);
         end
         ACT_MUL: begin
            xr = 68'(ar) * 68'(br) - 68'(ai) * 68'(bi);
            xi = 68'(ar) * 68'(bi) + 68'(br) * 68'(ai);
         end
         default: begin
            xr = 68'(ar) * 68'(br) + 68'(ai) * 68'(bi);
            xi = 68'(ai) * 68'(br) - 68'(ar) * 68'(bi);
         end
      endcase
      mr = 128'(xr < 0 ? -xr : xr);
      mi = 128'(xi < 0 ? -xi : xi);
      if (act == ACT_MUL) begin
         mr = mr >> FRAC_BITS;
         mi = mi >> FRAC_BITS;
      end else if (act == ACT_DIV) begin
         if (br == 0 && bi == 0) begin
            r.re = '0;
            r.im = '0;
            r.status = ST_DBZ;
            return r;
         end
         den = 128'(68'(br) * 68'(br) + 68'(bi) * 68'(bi));
         mr = (mr << FRAC_BITS) / den;
         mi = (mi << FRAC_BITS) / den;
      end
      r.re = clamp_part(xr < 0, mr, sat);
      r.im = clamp_part(xi < 0, mi, sat);
      r.status = sat ? ST_SAT : ST_OK;
      return r;
   endfunction

   class result_scoreboard_type;
      cplx_result_type pending[$];
      int errors = 0;
      int checked = 0;
      int n_sat = 0;
      int n_dbz = 0;

      function void note_item(action_type act, logic signed [31:0] ar,
                              logic signed [31:0] ai, logic signed [31:0] br,
                              logic signed [31:0] bi);
         pending.push_back(complex_result(act, ar, ai, br, bi));
      endfunction

      function void check_result(logic signed [31:0] re, logic signed [31:0] im,
                                 logic [1:0] st);
         cplx_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected re=%h im=%h st=%0d",
                     $time, re, im, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.status == ST_SAT) n_sat++;
         if (e.status == ST_DBZ) n_dbz++;
         if (re !== e.re) begin
            $display("%0t: res_re expected %h actual %h", $time, e.re, re);
            errors++;
         end
         if (im !== e.im) begin
            $display("%0t: res_im expected %h actual %h", $time, e.im, im);
            errors++;
         end
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic signed [31:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic [1:0] rsp_status;

   result_scoreboard_type sb = new();
   int cycle_count = 0;
   int items_sent = 0;
   int hold_count = 0;

   complex_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_a_re(req_a_re), .req_a_im(req_a_im),
      .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im), .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit: far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Sample both handshakes at the rising edge, before the block updates.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_item(action_type'(req_action), req_a_re, req_a_im,
                         req_b_re, req_b_im);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_res_re, rsp_res_im, rsp_status);
      end
   end

   // Receiver: stall on a changing random rate, with quiet stretches, and
   // hold off for long stretches twice so the pipeline fills and backs up.
   initial begin
      int stall_pct;
      int phase_left;
      stall_pct = 0;
      phase_left = 0;
      forever begin
         @(negedge clock);
         if (cycle_count == 1500 || cycle_count == 6000)
            hold_count = 120;
         if (phase_left == 0) begin
            phase_left = $urandom_range(300, 50);
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         phase_left--;
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   int burst_left = 0;

   // Offer one item and hold it until taken; then maybe leave a gap.
   task automatic send_item(input action_type act, input logic [31:0] ar,
                            input logic [31:0] ai, input logic [31:0] br,
                            input logic [31:0] bi);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(30, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Operand part: extremes, small Q16.16 values, or any pattern.
   function automatic logic [31:0] pick_part();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         5, 6: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      action_type act;
      logic [31:0] br, bi;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of each operation, divide by zero, saturation.
      send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(ACT_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
      send_item(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(ACT_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
      send_item(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
      send_item(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
      send_item(ACT_MUL, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
      send_item(ACT_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(ACT_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
      send_item(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
      send_item(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(ACT_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_DIV, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0000_0001);
      send_item(ACT_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);

      // Random items; a slice of divides gets a zero divisor.
      repeat (1330) begin
         act = action_type'($urandom_range(3));
         br = pick_part();
         bi = pick_part();
         if (act == ACT_DIV && $urandom_range(15) == 0) begin
            br = '0;
            bi = '0;
         end
         send_item(act, pick_part(), pick_part(), br, bi);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then let the full pipeline depth pass.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d items, checked %0d results (%0d saturated, %0d divide by zero).",
               items_sent, sb.checked, sb.n_sat, sb.n_dbz);
      $display("Covered all four operations with random sender gaps and receiver stalls.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_pack.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
sim/tb_complex_arithmetic_unit.sv
